// ===== rtl/swm_pkg.sv =====
package swm_pkg;

  // Width of the window_size register and its value after reset.
  localparam int unsigned CFG_BITS  = 7;
  localparam int unsigned CFG_RESET = 3;

  // Commands from the controller to the datapath, at most two at a time.
  typedef struct packed {
    logic take;       // capture the input item, clear the window on start
    logic ring_rd;    // read the oldest sample from the arrival ring
    logic scan_init;  // restart the removal scan at entry zero
    logic scan_rd;    // read the sorted entry under the scan index
    logic rm_step;    // compare or shift one sorted entry during removal
    logic rm_last;    // last removal step: shrink the count by one
    logic ins_init;   // point the insert index at the end of the list
    logic ins_rd;     // read the sorted entry just below the insert index
    logic ins_shift;  // move the entry read one place up
    logic ins_put;    // write the new sample under the insert index
    logic finish;     // update the ring and read the upper middle entry
    logic med_lo;     // hold the upper middle entry, read the lower one
    logic out_load;   // load the result into the output register
  } swm_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;       // the window holds its full length
    logic scan_last;  // the removal scan is at the last valid entry
    logic idx_zero;   // the insert index has reached the bottom
    logic gt;         // the entry read is greater than the new sample
    logic out_free;   // the output register can take a result this cycle
  } swm_sts_t;

endpackage

// ===== rtl/sliding_window_median_unit.sv =====
// Sliding-window median filter.
// Each input item carries one signed sample (s_axis_tdata) and a start flag
// (s_axis_tuser) that empties the window before the sample is taken. Once the
// window holds window_size samples, every item gives one result item on the
// m_axis channel: twice the window median, so that an even window's average
// of the two middle values stays exact. While the window fills, items give no
// result. The window length is written on the cfg port (clamped to 1 and
// WINDOW_MAX) and writing it also empties the window.
// With a full window the time from acceptance to a valid result depends on how
// far the new sample moves in the sorted list, and it is set by the sorted store's
// single read port, which the removal and the insertion walk entry by entry. The
// controller takes no new item until it is idle again; it is idle from the cycle in
// which the result becomes valid. Items that only fill the window are done once
// the new sample is inserted and the ring is updated.
// Results wait in an output register: the next item is taken and worked on
// while the receiver stalls, and only its own result waits for the register.
// Reset sets the length to 3 and empties the window; the stores need no pass.
module sliding_window_median_unit #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration: window_size
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swm_pkg::CFG_BITS-1:0] cfg_data_i,
  // Input items
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample
  input  logic                         s_axis_tuser,      // start_sequence
  // Result items
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0] m_axis_tdata   // median_doubled
);

  localparam int unsigned OUT_W = ((SAMPLE_BITS + 8) / 8) * 8;

  swm_pkg::swm_cmd_t    cmd;
  swm_pkg::swm_sts_t    sts;
  logic [SAMPLE_BITS:0] median2;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata[SAMPLE_BITS-1:0]),
    .start_i     (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (median2)
  );

  // Result padded with zeros to whole bytes.
  assign m_axis_tdata = OUT_W'(median2);

endmodule

// ===== rtl/swm_ctrl.sv =====
module swm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  swm_pkg::swm_sts_t sts_i,
  output swm_pkg::swm_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b0_0000_0001,
    ST_CHECK   = 9'b0_0000_0010,
    ST_RM_RD   = 9'b0_0000_0100,
    ST_RM_ACT  = 9'b0_0000_1000,
    ST_INS_RD  = 9'b0_0001_0000,
    ST_INS_ACT = 9'b0_0010_0000,
    ST_FIN     = 9'b0_0100_0000,
    ST_MED_B   = 9'b0_1000_0000,
    ST_MED_C   = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Only an idle controller takes a new item.
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: once the window is full remove the oldest sample, insert the new one, and then read the median.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.full) begin
          cmd_o.ring_rd   = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = ST_RM_RD;
        end else begin
          cmd_o.ins_init = 1'b1;
          state_d        = ST_INS_RD;
        end
      end
      ST_RM_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_RM_ACT;
      end
      ST_RM_ACT: begin
        cmd_o.rm_step = 1'b1;
        if (sts_i.scan_last) begin
          cmd_o.rm_last = 1'b1;
          state_d       = ST_INS_RD;
        end else begin
          state_d = ST_RM_RD;
        end
      end
      ST_INS_RD: begin
        if (sts_i.idx_zero) begin
          cmd_o.ins_put = 1'b1;
          state_d       = ST_FIN;
        end else begin
          cmd_o.ins_rd = 1'b1;
          state_d      = ST_INS_ACT;
        end
      end
      ST_INS_ACT: begin
        if (sts_i.gt) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = ST_INS_RD;
        end else begin
          cmd_o.ins_put = 1'b1;
          state_d       = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = sts_i.full ? ST_MED_B : ST_IDLE;
      end
      ST_MED_B: begin
        cmd_o.med_lo = 1'b1;
        state_d      = ST_MED_C;
      end
      ST_MED_C: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/swm_datapath.sv =====
module swm_datapath #(
  parameter int unsigned WINDOW_MAX  = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swm_pkg::CFG_BITS-1:0] cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  input  logic                         start_i,
  input  swm_pkg::swm_cmd_t            cmd_i,
  output swm_pkg::swm_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [SAMPLE_BITS:0]         out_data_o
);

  localparam int unsigned AW = $clog2(WINDOW_MAX);
  localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SIZE_RST =
    (swm_pkg::CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : swm_pkg::CFG_RESET;

  // Window length after clamping to the range one to WINDOW_MAX.
  function automatic logic [CW-1:0] clamp_size(input logic [swm_pkg::CFG_BITS-1:0] raw);
    logic [CW-1:0] res;
    if (raw == '0) begin
      res = CW'(1);
    end else if (int'(raw) > int'(WINDOW_MAX)) begin
      res = CW'(WINDOW_MAX);
    end else begin
      res = CW'(raw);
    end
    return res;
  endfunction

  logic [CW-1:0] size_q, size_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          found_q, found_d;
  logic          out_valid_q, out_valid_d;

  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [SAMPLE_BITS-1:0] rd_q;
  logic signed [SAMPLE_BITS-1:0] ring_q;
  logic signed [SAMPLE_BITS-1:0] med_a_q;
  logic        [SAMPLE_BITS:0]   out_data_q;

  logic signed [SAMPLE_BITS-1:0] sorted_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] ring_mem   [WINDOW_MAX];

  logic                          cfg_wr;
  logic [CW-1:0]                 idx_dec;
  logic [CW-1:0]                 idx_inc;
  logic [CW-1:0]                 pos_inc;
  logic [CW-1:0]                 half_size;
  logic [AW-1:0]                 mid_hi;
  logic [AW-1:0]                 mid_lo;
  logic                          srt_re;
  logic [AW-1:0]                 srt_raddr;
  logic                          srt_we;
  logic [AW-1:0]                 srt_waddr;
  logic signed [SAMPLE_BITS-1:0] srt_wdata;
  logic [SAMPLE_BITS:0]          median2;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  assign idx_dec   = idx_q - CW'(1);
  assign idx_inc   = idx_q + CW'(1);
  assign pos_inc   = CW'(pos_q) + CW'(1);
  assign half_size = size_q >> 1;
  assign mid_hi    = half_size[AW-1:0];
  assign mid_lo    = mid_hi - AW'(1);

  // Status back to the controller.
  assign sts_o.full      = (cnt_q == size_q);
  assign sts_o.scan_last = (idx_inc == cnt_q);
  assign sts_o.idx_zero  = (idx_q == '0);
  assign sts_o.gt        = (rd_q > samp_q);
  assign sts_o.out_free  = ~out_valid_q | out_ready_i;

  // Read and write ports of the sorted store.
  always_comb begin
    srt_re    = 1'b0;
    srt_raddr = idx_q[AW-1:0];
    srt_we    = 1'b0;
    srt_waddr = idx_q[AW-1:0];
    srt_wdata = samp_q;
    if (cmd_i.scan_rd) begin
      srt_re = 1'b1;
    end
    if (cmd_i.ins_rd) begin
      srt_re    = 1'b1;
      srt_raddr = idx_dec[AW-1:0];
    end
    if (cmd_i.finish) begin
      srt_re    = 1'b1;
      srt_raddr = mid_hi;
    end
    if (cmd_i.med_lo) begin
      srt_re    = 1'b1;
      srt_raddr = mid_lo;
    end
    if (cmd_i.rm_step && found_q) begin
      srt_we    = 1'b1;
      srt_waddr = idx_dec[AW-1:0];
      srt_wdata = rd_q;
    end
    if (cmd_i.ins_shift) begin
      srt_we    = 1'b1;
      srt_wdata = rd_q;
    end
    if (cmd_i.ins_put) begin
      srt_we = 1'b1;
    end
  end

  // Sorted store.
  always_ff @(posedge clk_i) begin
    if (srt_re) begin
      rd_q <= sorted_mem[srt_raddr];
    end
    if (srt_we) begin
      sorted_mem[srt_waddr] <= srt_wdata;
    end
  end

  // Arrival ring.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_rd) begin
      ring_q <= ring_mem[pos_q];
    end
    if (cmd_i.finish) begin
      ring_mem[pos_q] <= samp_q;
    end
  end

  // Next values of the window bookkeeping and the output flag.
  always_comb begin
    size_d      = size_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    found_d     = found_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.take && start_i) begin
      cnt_d = '0;
      pos_d = '0;
    end
    if (cmd_i.scan_init) begin
      idx_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.rm_step) begin
      idx_d = idx_inc;
      if (!found_q && (rd_q == ring_q)) begin
        found_d = 1'b1;
      end
    end
    if (cmd_i.rm_last) begin
      cnt_d = cnt_q - CW'(1);
      idx_d = cnt_q - CW'(1);
    end
    if (cmd_i.ins_init) begin
      idx_d = cnt_q;
    end
    if (cmd_i.ins_shift) begin
      idx_d = idx_dec;
    end
    if (cmd_i.ins_put) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cmd_i.finish) begin
      pos_d = (pos_inc >= size_q) ? '0 : pos_inc[AW-1:0];
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
    if (cfg_wr) begin
      size_d = clamp_size(cfg_data_i);
      cnt_d  = '0;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= CW'(SIZE_RST);
      cnt_q       <= '0;
      pos_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Twice the median: the middle entry doubled, or the two middle entries added.
  always_comb begin
    if (size_q[0]) begin
      median2 = {med_a_q, 1'b0};
    end else begin
      median2 = {med_a_q[SAMPLE_BITS-1], med_a_q} + {rd_q[SAMPLE_BITS-1], rd_q};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      samp_q <= sample_i;
    end
    if (cmd_i.med_lo) begin
      med_a_q <= rd_q;
    end
    if (cmd_i.out_load) begin
      out_data_q <= median2;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The fill count never runs past the window length.
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= size_q)
    else $error("fill count above window length");

  // The ring write position stays inside the window.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(pos_q) < size_q)
    else $error("ring position outside the window");

  // The oldest sample is always present in the sorted store.
  a_old_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rm_last |-> (found_q || (rd_q == ring_q)))
    else $error("oldest sample missing from sorted store");

  // A result is only loaded when the output register can take it.
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

endmodule
